FILE: rtl/bspl_pkg.sv
// Shared types and codes for the B-spline point evaluator.
`default_nettype none
package bspl_pkg;

  localparam int FIELD_W    = 16;
  localparam int SLOT_W     = 5;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int WEIGHT_W   = 16;
  localparam int WCNT_W     = $clog2(WEIGHT_W);

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_KNOT  = 2'd0;
  localparam mode_t MODE_POINT = 2'd1;
  localparam mode_t MODE_EVAL  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_SPAN = 2'd1;
  localparam status_t STATUS_ZERO_GAP = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEGREE      = 2'd0;
  localparam cfg_idx_t REG_KNOT_COUNT  = 2'd1;
  localparam cfg_idx_t REG_POINT_COUNT = 2'd2;

  localparam logic [2:0] DEGREE_RESET = 3'd3;

endpackage
`default_nettype wire

FILE: rtl/bspl_item_if.sv
// Valid/ready channels for input items and result items.
`default_nettype none
interface bspl_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [4:0]         entry_index;
  logic [15:0]        knot_value;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic [4:0]         span_index;
  logic [15:0]        param;
  modport source (output valid, mode, entry_index, knot_value, point_x, point_y, point_z,
                  span_index, param, input ready);
  modport sink (input valid, mode, entry_index, knot_value, point_x, point_y, point_z,
                span_index, param, output ready);
endinterface

interface bspl_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] curve_x;
  logic signed [15:0] curve_y;
  logic signed [15:0] curve_z;
  logic [1:0]         status;
  modport source (output valid, curve_x, curve_y, curve_z, status, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/de_boor_bspline_eval.sv
// Evaluates a B-spline curve point from a knot store and a control point store (de Boor).
//
// Knot and point write words go into their stores as they are accepted. An evaluate word
// copies degree+1 points into the working triangle (a read and a write state per point),
// then runs degree*(degree+1)/2 blend steps. Each step reads knots and triangle entries,
// derives the weight with a bit-serial restoring divider (skipped when the weight is
// clamped or the interval is empty), runs a bit-serial shift-add multiplier over the 16
// weight bits for all three coordinates, and writes back. One evaluation runs at a time;
// write words are taken only between evaluations. A finished point waits in the output
// register.
`default_nettype none
module de_boor_bspline_eval
  import bspl_pkg::*;
#(
  parameter int POINT_DEPTH = 16,
  parameter int KNOT_DEPTH  = 32,
  parameter int MAX_DEGREE  = 7,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  bspl_item_if.sink                  item,
  bspl_result_if.source              result
);

  localparam int KW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1;
  localparam int PW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int TW = $clog2(MAX_DEGREE + 1);
  localparam int CW = $clog2(KNOT_DEPTH + POINT_DEPTH + 64) + 1;
  localparam int AW = COORD_WIDTH + WEIGHT_W + 1;
  localparam int SW = COORD_WIDTH + WEIGHT_W + 2;
  localparam int VW = 3 * COORD_WIDTH;

  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (WEIGHT_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_RD_A0, S_RD_T0, S_RD_T1, S_LD_T1,
    S_WEIGHT, S_DIV, S_MUL, S_WR, S_FIN_RD, S_FINISH
  } state_t;

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
      sat_coord = r[COORD_WIDTH-1:0];
    end
  endfunction

  // configuration
  logic [2:0] degree;
  logic [5:0] knot_count;
  logic [4:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= DEGREE_RESET;
      knot_count  <= '0;
      point_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE:      degree      <= cfg_data[2:0];
        REG_KNOT_COUNT:  knot_count  <= cfg_data;
        REG_POINT_COUNT: point_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [FIELD_W-1:0] knot_mem [KNOT_DEPTH];
  logic [VW-1:0]      point_mem [POINT_DEPTH];
  logic [VW-1:0]      tri_mem [MAX_DEGREE+1];
  logic [FIELD_W-1:0] knot_rd;
  logic [VW-1:0]      point_rd;
  logic [VW-1:0]      tri_rd;
  logic [KW-1:0]      knot_addr;
  logic [PW-1:0]      point_addr;
  logic [TW-1:0]      tri_addr;
  logic               tri_we;
  logic [TW-1:0]      tri_waddr;
  logic [VW-1:0]      tri_wdata;

  state_t state;
  logic   accept;
  logic [CW-1:0] slot_w;
  logic          knot_we;
  logic          point_we;
  logic [VW-1:0] point_wdata;

  assign accept   = item.valid && item.ready;
  assign slot_w   = CW'(item.entry_index);
  assign knot_we  = accept && (item.mode == MODE_KNOT) && (slot_w < CW'(KNOT_DEPTH));
  assign point_we = accept && (item.mode == MODE_POINT) && (slot_w < CW'(POINT_DEPTH));
  assign point_wdata = {sat_coord(SW'(item.point_z)), sat_coord(SW'(item.point_y)),
                        sat_coord(SW'(item.point_x))};

  always_ff @(posedge clk) begin
    if (knot_we) knot_mem[slot_w[KW-1:0]] <= item.knot_value;
    knot_rd <= knot_mem[knot_addr];
  end

  always_ff @(posedge clk) begin
    if (point_we) point_mem[slot_w[PW-1:0]] <= point_wdata;
    point_rd <= point_mem[point_addr];
  end

  always_ff @(posedge clk) begin
    if (tri_we) tri_mem[tri_waddr] <= tri_wdata;
    tri_rd <= tri_mem[tri_addr];
  end

  // evaluation registers
  logic [4:0]          span_r;
  logic [FIELD_W-1:0]  x_r;
  logic [TW-1:0]       deg_r;
  logic [TW-1:0]       j_r;
  logic [TW-1:0]       k_r;
  logic [TW-1:0]       i_r;
  logic [FIELD_W-1:0]  t0_r;
  logic [FIELD_W-1:0]  t1_r;
  logic [FIELD_W-1:0]  den_r;
  logic [FIELD_W-1:0]  rem_r;
  logic [WEIGHT_W-1:0] w_sh;
  logic [WCNT_W-1:0]   cnt;
  logic [2:0][COORD_WIDTH-1:0] a_lo;
  logic [2:0][COORD_WIDTH-1:0] a_hi;
  logic [2:0][AW-1:0]          acc;
  logic [2:0][AW-1:0]          acc_next;
  logic [2:0][COORD_WIDTH-1:0] blend;
  logic    err_r;
  status_t status_r;

  // range check for an arriving evaluate word
  logic [CW-1:0] d_c, kc_c, pc_c, s_c;
  logic          span_ok;
  always_comb begin
    d_c  = (CW'(degree) > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : CW'(degree);
    kc_c = (CW'(knot_count) > CW'(KNOT_DEPTH)) ? CW'(KNOT_DEPTH) : CW'(knot_count);
    pc_c = (CW'(point_count) > CW'(POINT_DEPTH)) ? CW'(POINT_DEPTH) : CW'(point_count);
    s_c  = CW'(item.span_index);
    span_ok = (s_c >= d_c) && (s_c < pc_c) && (s_c + d_c < kc_c);
  end

  // read addresses
  logic [CW-1:0] p_idx, lo_idx, hi_idx;
  logic [TW:0]   i_inc;
  always_comb begin
    p_idx  = CW'(span_r) - CW'(j_r);
    lo_idx = CW'(span_r) + CW'(1) + CW'(i_r) - CW'(k_r);
    hi_idx = CW'(span_r) + CW'(1) + CW'(i_r);
    i_inc  = (TW+1)'(i_r) + (TW+1)'(1);
    point_addr = p_idx[PW-1:0];
    knot_addr  = (state == S_RD_T1) ? hi_idx[KW-1:0] : lo_idx[KW-1:0];
    tri_addr   = '0;
    if (state == S_RD_T1) tri_addr = i_inc[TW-1:0];
  end

  // divider step, multiplier step, rounding of the blend
  logic [FIELD_W:0] rem2;
  logic             q_bit;
  assign rem2  = {rem_r, 1'b0};
  assign q_bit = (rem2 >= {1'b0, den_r});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [AW-1:0] diff;
      logic signed [SW-1:0] sum;
      diff = AW'($signed(a_hi[c])) - AW'($signed(a_lo[c]));
      acc_next[c] = (acc[c] << 1) + (w_sh[WEIGHT_W-1] ? diff : AW'(0));
      sum = (SW'($signed(a_lo[c])) <<< WEIGHT_W) + SW'($signed(acc[c])) + HALF;
      blend[c] = sat_coord(sum >>> WEIGHT_W);
    end
  end

  always_comb begin
    tri_we    = 1'b0;
    tri_waddr = deg_r - j_r;
    tri_wdata = point_rd;
    if (state == S_CP_WR) tri_we = 1'b1;
    if (state == S_WR) begin
      tri_we    = 1'b1;
      tri_waddr = i_r;
      tri_wdata = {blend[2], blend[1], blend[0]};
    end
  end

  assign item.ready = (state == S_IDLE) && !rst;

  logic [FIELD_W-1:0] tri_x, tri_y, tri_z;
  assign tri_x = FIELD_W'(SW'($signed(tri_rd[COORD_WIDTH-1:0])));
  assign tri_y = FIELD_W'(SW'($signed(tri_rd[2*COORD_WIDTH-1:COORD_WIDTH])));
  assign tri_z = FIELD_W'(SW'($signed(tri_rd[VW-1:2*COORD_WIDTH])));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FINISH) result.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item.mode == MODE_EVAL) begin
            span_r   <= item.span_index;
            x_r      <= item.param;
            deg_r    <= d_c[TW-1:0];
            j_r      <= '0;
            status_r <= STATUS_OK;
            err_r    <= !span_ok;
            state    <= span_ok ? S_CP_RD : S_FINISH;
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          if (j_r == deg_r) begin
            k_r   <= deg_r;
            i_r   <= '0;
            state <= (deg_r == '0) ? S_FIN_RD : S_RD_A0;
          end else begin
            j_r   <= j_r + TW'(1);
            state <= S_CP_RD;
          end
        end
        S_RD_A0: state <= S_RD_T0;
        S_RD_T0: begin
          if (i_r == '0) a_lo <= tri_rd;
          state <= S_RD_T1;
        end
        S_RD_T1: begin
          t0_r  <= knot_rd;
          state <= S_LD_T1;
        end
        S_LD_T1: begin
          t1_r  <= knot_rd;
          a_hi  <= tri_rd;
          state <= S_WEIGHT;
        end
        S_WEIGHT: begin
          acc <= '0;
          cnt <= '0;
          if (t1_r <= t0_r) begin
            w_sh     <= '0;
            status_r <= STATUS_ZERO_GAP;
            state    <= S_MUL;
          end else if (x_r <= t0_r) begin
            w_sh  <= '0;
            state <= S_MUL;
          end else if (x_r >= t1_r) begin
            w_sh  <= '1;
            state <= S_MUL;
          end else begin
            rem_r <= x_r - t0_r;
            den_r <= t1_r - t0_r;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          rem_r <= q_bit ? FIELD_W'(rem2 - {1'b0, den_r}) : rem2[FIELD_W-1:0];
          w_sh  <= {w_sh[WEIGHT_W-2:0], q_bit};
          cnt   <= cnt + WCNT_W'(1);
          if (cnt == WCNT_W'(WEIGHT_W - 1)) begin
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // weight bits MSB first
          acc  <= acc_next;
          w_sh <= {w_sh[WEIGHT_W-2:0], 1'b0};
          cnt  <= cnt + WCNT_W'(1);
          if (cnt == WCNT_W'(WEIGHT_W - 1)) state <= S_WR;
        end
        S_WR: begin
          a_lo <= a_hi;
          if (i_inc == (TW+1)'(k_r)) begin
            i_r <= '0;
            if (k_r == TW'(1)) begin
              state <= S_FIN_RD;
            end else begin
              k_r   <= k_r - TW'(1);
              state <= S_RD_A0;
            end
          end else begin
            i_r   <= i_inc[TW-1:0];
            state <= S_RD_T0;
          end
        end
        S_FIN_RD: state <= S_FINISH;
        S_FINISH: begin
          // hold until the output register is free
          if (!result.valid || result.ready) begin
            result.valid   <= 1'b1;
            result.curve_x <= err_r ? '0 : tri_x;
            result.curve_y <= err_r ? '0 : tri_y;
            result.curve_z <= err_r ? '0 : tri_z;
            result.status  <= err_r ? STATUS_BAD_SPAN : status_r;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
